@@ rtl/fnwm_pkg.sv @@
// Shared types and constants for the fixed-length filename wildcard matcher.
// No dependencies; used by fnwm_cell, the top level and the checker.
package fnwm_pkg;

    // Name and pattern geometry
    localparam int NAME_LEN    = 12;
    localparam int PATTERN_MAX = 16;
    localparam int NUM_POS     = PATTERN_MAX + 1;    // pattern positions incl. end position
    localparam int POS_W       = $clog2(NUM_POS);
    localparam int CNT_W       = 4;
    localparam int CFG_W       = 64;
    localparam int LEN_W       = 5;

    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(NAME_LEN - 1);

    // Special pattern and name bytes
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] ANY_BYTE   = 8'h3F;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2
    } cfg_index_t;

    // Static control of one cell
    typedef struct packed {
        logic in_use;    // position lies inside the pattern
        logic is_end;    // position is the pattern end
        logic init_val;  // active value after reset and at name start
        logic restart;   // last byte of a name: reload init value
    } cell_ctrl_t;

    // Data handed from one cell to its right neighbor
    typedef struct packed {
        logic cur;   // live star passes liveness on this byte
        logic adv;   // byte matched, next position becomes live
        logic fin;   // live star passes liveness in the final closure
    } cell_link_t;

endpackage

@@ rtl/fixed_name_wildcard_matcher_top.sv @@
// The decision is registered on matched in the cycle after the last name byte is accepted.
// Throughput: one name byte per cycle through a single pass of the 17-cell chain;
// a request is refused only on the last byte of a name while a result waits.
// Reset (async, active low): pattern registers and length cleared, position
// zero active, byte count and early accept cleared, no result pending.
// Depends on fnwm_pkg and fnwm_cell.
module fixed_name_wildcard_matcher_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port
    input  logic                        cfg_write_en,
    input  logic [1:0]                  cfg_index,
    input  logic [fnwm_pkg::CFG_W-1:0]  cfg_data,
    // Name byte channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  name_byte,
    // Result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        matched
);

    logic [fnwm_pkg::CFG_W-1:0] pat_lo_reg;
    logic [fnwm_pkg::CFG_W-1:0] pat_hi_reg;
    logic [fnwm_pkg::LEN_W-1:0] pat_len_reg;

    logic [fnwm_pkg::CNT_W-1:0] cnt_reg;
    logic [fnwm_pkg::CNT_W-1:0] cnt_next;
    logic                       early_reg;
    logic                       early_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       matched_reg;
    logic                       matched_next;

    logic [fnwm_pkg::LEN_W-1:0] len;
    logic                       step;
    logic                       last;
    logic                       acc;
    logic                       done;

    logic [7:0]                 pat [fnwm_pkg::NUM_POS];
    fnwm_pkg::cell_ctrl_t       ctrl [fnwm_pkg::NUM_POS];
    fnwm_pkg::cell_link_t       link [fnwm_pkg::NUM_POS];
    logic [fnwm_pkg::NUM_POS-1:0] zero_vec;
    logic [fnwm_pkg::NUM_POS-1:0] end_vec;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                fnwm_pkg::CFG_PAT_LO:  pat_lo_reg  <= cfg_data;
                fnwm_pkg::CFG_PAT_HI:  pat_hi_reg  <= cfg_data;
                fnwm_pkg::CFG_PAT_LEN: pat_len_reg <= cfg_data[fnwm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length, clamped to the maximum
    assign len = (pat_len_reg > fnwm_pkg::LEN_W'(fnwm_pkg::PATTERN_MAX)) ?
                 fnwm_pkg::LEN_W'(fnwm_pkg::PATTERN_MAX) : pat_len_reg;

    // Handshake: hold off only when this byte would produce a result that cannot be stored
    assign last     = (cnt_reg == fnwm_pkg::LAST_BYTE);
    assign in_ready = ~out_valid_reg | out_ready | ~last;
    assign step     = in_valid & in_ready;

    // Cell chain
    genvar p;
    generate
        for (p = 0; p < fnwm_pkg::NUM_POS; p++)
        begin : g_cell
            fnwm_pkg::cell_link_t link_in;

            if (p < 8)
            begin : g_lo
                assign pat[p] = pat_lo_reg[8*p +: 8];
            end
            else if (p < fnwm_pkg::PATTERN_MAX)
            begin : g_hi
                assign pat[p] = pat_hi_reg[8*(p-8) +: 8];
            end
            else
            begin : g_end
                assign pat[p] = fnwm_pkg::NUL_BYTE;
            end

            if (p == 0)
            begin : g_first
                assign link_in = '0;
            end
            else
            begin : g_next
                assign link_in = link[p-1];
            end

            assign ctrl[p].in_use   = (fnwm_pkg::LEN_W'(p) < len);
            assign ctrl[p].is_end   = (fnwm_pkg::LEN_W'(p) == len);
            assign ctrl[p].init_val = (p == 0);
            assign ctrl[p].restart  = last;

            fnwm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (step),
                .ctrl       (ctrl[p]),
                .pat_byte   (pat[p]),
                .name_byte  (name_byte),
                .link_in    (link_in),
                .link_out   (link[p]),
                .accept_zero(zero_vec[p]),
                .end_hit    (end_vec[p])
            );
        end
    endgenerate

    // Decision for this byte
    assign acc  = early_reg | (|zero_vec);
    assign done = acc | (|end_vec);

    // Byte count, early accept and result register
    always_comb
    begin
        cnt_next       = cnt_reg;
        early_next     = early_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        matched_next   = matched_reg;
        if (step)
        begin
            if (last)
            begin
                cnt_next       = '0;
                early_next     = 1'b0;
                out_valid_next = 1'b1;
                matched_next   = done;
            end
            else
            begin
                cnt_next   = cnt_reg + 1'b1;
                early_next = acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            early_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            early_reg     <= early_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

@@ rtl/fnwm_cell.sv @@
// One pattern position of the matcher chain: holds its active bit and passes
// star ripple and match advance to the next position. Depends on fnwm_pkg.
module fnwm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  fnwm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          pat_byte,
    input  logic [7:0]          name_byte,
    input  fnwm_pkg::cell_link_t link_in,
    output fnwm_pkg::cell_link_t link_out,
    output logic                accept_zero,
    output logic                end_hit
);

    logic active_reg;
    logic active_next;
    logic kept;
    logic cur;
    logic is_star;
    logic stay;
    logic end_live;
    logic nxt;
    logic fin;

    // Live set for this byte, with star ripple from the left
    assign kept    = active_reg & (ctrl.in_use | ctrl.is_end);
    assign cur     = kept | link_in.cur;
    assign is_star = (pat_byte == fnwm_pkg::STAR_BYTE);
    assign stay    = ctrl.in_use & cur & is_star;

    // Hand-off to the right neighbor
    assign link_out.cur = stay;
    assign link_out.adv = ctrl.in_use & cur & ~is_star &
                          ((pat_byte == fnwm_pkg::ANY_BYTE) | (pat_byte == name_byte));
    assign link_out.fin = fin & is_star & ctrl.in_use;

    // End position: space keeps alive, zero accepts at once
    assign end_live    = ctrl.is_end & cur;
    assign accept_zero = end_live & (name_byte == fnwm_pkg::NUL_BYTE);

    assign nxt     = stay | link_in.adv | (end_live & (name_byte == fnwm_pkg::SPACE_BYTE));
    // Final star closure over the next set, used on the last byte
    assign fin     = nxt | link_in.fin;
    assign end_hit = fin & ctrl.is_end;

    always_comb
    begin
        active_next = active_reg;
        if (step)
        begin
            active_next = ctrl.restart ? ctrl.init_val : nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ctrl.init_val;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

@@ rtl/fnwm_checker.sv @@
// Port-level checks for the wildcard matcher, bound to the top level.
// Depends on fnwm_pkg and fixed_name_wildcard_matcher_top.
module fnwm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       matched
);

    logic [fnwm_pkg::CNT_W-1:0] seen_reg;
    logic                       in_fire;
    logic                       in_last;

    assign in_fire = in_valid & in_ready;
    assign in_last = in_fire & (seen_reg == fnwm_pkg::LAST_BYTE);

    // Count accepted bytes within the current name
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (in_fire)
        begin
            seen_reg <= in_last ? '0 : seen_reg + 1'b1;
        end
    end

    // A held result keeps its decision
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched))
        else $error("result dropped or changed while stalled");

    // The last byte of a name always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_last |=> out_valid)
        else $error("no result after last name byte");

    // A new result only follows the last byte of a name
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_last))
        else $error("result without a completed name");

    // Input is refused only when a result is stuck at the output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind fixed_name_wildcard_matcher_top fnwm_checker u_fnwm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched  (matched)
);
